FILE: hw/rtl/csd_pkg.sv
// Types, constants and helpers for the command sequence detector.
package csd_pkg;

    localparam int CHAR_W = 8;
    localparam int FLAG_W = 2;

    localparam logic [CHAR_W-1:0] CH_BANG = 8'h21;
    localparam logic [CHAR_W-1:0] CH_HASH = 8'h23;
    localparam logic [CHAR_W-1:0] CH_R    = 8'h52;
    localparam logic [CHAR_W-1:0] CH_S    = 8'h53;
    localparam logic [CHAR_W-1:0] CH_T    = 8'h54;
    localparam logic [CHAR_W-1:0] CH_O    = 8'h4F;
    localparam logic [CHAR_W-1:0] CH_K    = 8'h4B;
    localparam logic [CHAR_W-1:0] CASE_BIT = 8'h20;

    localparam logic [FLAG_W-1:0] FLAG_NONE = 2'd0;
    localparam logic [FLAG_W-1:0] FLAG_RST  = 2'd1;
    localparam logic [FLAG_W-1:0] FLAG_OK   = 2'd2;

    typedef enum logic [8:0] {
        ST_IDLE    = 9'b000000001,
        ST_BANG    = 9'b000000010,
        ST_R       = 9'b000000100,
        ST_S       = 9'b000001000,
        ST_T       = 9'b000010000,
        ST_RSTDONE = 9'b000100000,
        ST_O       = 9'b001000000,
        ST_K       = 9'b010000000,
        ST_OKDONE  = 9'b100000000
    } t_stage;

    // Match an upper-case letter in either case.
    function automatic logic is_letter(input logic [CHAR_W-1:0] c,
                                       input logic [CHAR_W-1:0] upper);
        is_letter = (c | CASE_BIT) == (upper | CASE_BIT);
    endfunction

endpackage

FILE: hw/rtl/command_sequence_detector.sv
// Command sequence detector: recognizes !RST# and !OK# in a byte stream.
//
//  channel | direction | handshake                  | payload
//  in      | to block  | i_in_valid / o_in_stall    | i_rx_char
//  out     | from block| o_out_valid / i_out_stall  | o_echo_valid, o_echo_char,
//          |           |                            | o_newline_valid, o_command_flag
//
// One item per cycle while the input is not stalled; its result appears in the cycle after acceptance.
// Throughput is set by the single stage register and the one-entry result register.
// Input stalls only while a result is held and the output side stalls.
// Synchronous active-low reset returns the detector to idle and clears the flag.
module command_sequence_detector (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [csd_pkg::CHAR_W-1:0]    i_rx_char,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_echo_valid,
    output logic [csd_pkg::CHAR_W-1:0]    o_echo_char,
    output logic                          o_newline_valid,
    output logic [csd_pkg::FLAG_W-1:0]    o_command_flag
);
    import csd_pkg::*;

    t_stage              r_stage, n_stage;
    logic [FLAG_W-1:0]   r_flag, n_flag;
    logic                r_out_valid, n_out_valid;
    logic                r_echo, n_echo;
    logic [CHAR_W-1:0]   r_char;
    logic                r_nl, n_nl;
    logic [FLAG_W-1:0]   r_out_flag;
    logic                w_in_acc;
    logic                w_out_acc;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_acc  = r_out_valid && !i_out_stall;

    always_comb begin
        n_stage = r_stage;
        n_flag  = r_flag;
        n_echo  = 1'b0;
        n_nl    = 1'b0;
        case (r_stage)
            ST_BANG: begin
                if (i_rx_char == CH_BANG) begin
                    n_stage = ST_BANG;
                end else if (is_letter(i_rx_char, CH_R)) begin
                    n_echo  = 1'b1;
                    n_stage = ST_R;
                end else if (is_letter(i_rx_char, CH_O)) begin
                    n_echo  = 1'b1;
                    n_stage = ST_O;
                end else begin
                    n_stage = ST_IDLE;
                end
            end
            ST_R: begin
                if (is_letter(i_rx_char, CH_R)) begin
                    n_stage = ST_R;
                end else if (is_letter(i_rx_char, CH_S)) begin
                    n_echo  = 1'b1;
                    n_stage = ST_S;
                end else begin
                    n_stage = ST_IDLE;
                end
            end
            ST_S: begin
                if (is_letter(i_rx_char, CH_S)) begin
                    n_stage = ST_S;
                end else if (is_letter(i_rx_char, CH_T)) begin
                    n_echo  = 1'b1;
                    n_stage = ST_T;
                end else begin
                    n_stage = ST_IDLE;
                end
            end
            ST_T: begin
                if (is_letter(i_rx_char, CH_T)) begin
                    n_stage = ST_T;
                end else if (i_rx_char == CH_HASH) begin
                    n_echo  = 1'b1;
                    n_stage = ST_RSTDONE;
                end else begin
                    n_stage = ST_IDLE;
                end
            end
            ST_O: begin
                if (is_letter(i_rx_char, CH_O)) begin
                    n_stage = ST_O;
                end else if (is_letter(i_rx_char, CH_K)) begin
                    n_echo  = 1'b1;
                    n_stage = ST_K;
                end else begin
                    n_stage = ST_IDLE;
                end
            end
            ST_K: begin
                if (is_letter(i_rx_char, CH_K)) begin
                    n_stage = ST_K;
                end else if (i_rx_char == CH_HASH) begin
                    n_echo  = 1'b1;
                    n_stage = ST_OKDONE;
                end else begin
                    n_stage = ST_IDLE;
                end
            end
            ST_RSTDONE: begin
                n_nl    = 1'b1;
                n_flag  = FLAG_RST;
                n_stage = ST_IDLE;
            end
            ST_OKDONE: begin
                n_nl    = 1'b1;
                n_flag  = FLAG_OK;
                n_stage = ST_IDLE;
            end
            default: begin
                if (i_rx_char == CH_BANG) begin
                    n_echo  = 1'b1;
                    n_stage = ST_BANG;
                end else begin
                    n_stage = ST_IDLE;
                end
            end
        endcase
    end

    assign n_out_valid = w_in_acc || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage     <= ST_IDLE;
            r_flag      <= FLAG_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (w_in_acc) begin
                r_stage <= n_stage;
                r_flag  <= n_flag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_echo     <= n_echo;
            r_char     <= i_rx_char;
            r_nl       <= n_nl;
            r_out_flag <= n_flag;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_echo_valid    = r_echo;
    assign o_echo_char     = r_char;
    assign o_newline_valid = r_nl;
    assign o_command_flag  = r_out_flag;

`ifndef NO_ASSERTIONS
    a_nl_has_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_newline_valid) |-> (o_command_flag != FLAG_NONE))
        else $error("newline without latched command");

    a_echo_nl_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_echo_valid && o_newline_valid))
        else $error("echo and newline in one item");

    a_rst_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && r_stage == ST_RSTDONE) |=>
            (o_newline_valid && o_command_flag == FLAG_RST))
        else $error("reset command not latched");

    a_ok_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && r_stage == ST_OKDONE) |=>
            (o_newline_valid && o_command_flag == FLAG_OK))
        else $error("ok command not latched");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && !w_in_acc) |=> !o_out_valid)
        else $error("result register not drained");
`endif

endmodule

FILE: verif/csd_checker.sv
// Result checker for the command sequence detector: predicts every result and compares it.
module csd_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  logic [csd_pkg::CHAR_W-1:0] i_rx_char,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  logic                       i_echo_valid,
    input  logic [csd_pkg::CHAR_W-1:0] i_echo_char,
    input  logic                       i_newline_valid,
    input  logic [csd_pkg::FLAG_W-1:0] i_command_flag,
    output int                         o_errors,
    output int                         o_pending
);
    import csd_pkg::*;

    typedef struct packed {
        logic              echo;
        logic [CHAR_W-1:0] ch;
        logic              newline;
        logic [FLAG_W-1:0] flag;
    } t_echo_result;

    t_stage            cmd_stage;
    logic [FLAG_W-1:0] latched_cmd;
    t_echo_result      echo_queue[$];
    int                mismatches = 0;
    int                waiting = 0;

    assign o_errors  = mismatches;
    assign o_pending = waiting;

    function automatic logic letter_match(input logic [CHAR_W-1:0] c,
                                          input logic [CHAR_W-1:0] upper);
        return c == upper || c == (upper | CASE_BIT);
    endfunction

    function automatic t_stage letter_step(input logic [CHAR_W-1:0] c,
                                           input logic [CHAR_W-1:0] cur_ch,
                                           input logic [CHAR_W-1:0] next_ch,
                                           input t_stage cur_st,
                                           input t_stage next_st,
                                           output logic echo);
        echo = 1'b0;
        if (letter_match(c, cur_ch))
            return cur_st;
        if (next_ch == CH_HASH ? c == CH_HASH : letter_match(c, next_ch)) begin
            echo = 1'b1;
            return next_st;
        end
        return ST_IDLE;
    endfunction

    function automatic t_echo_result predict_echo(input logic [CHAR_W-1:0] c);
        t_echo_result r;
        logic         e;
        r.echo    = 1'b0;
        r.ch      = c;
        r.newline = 1'b0;
        e         = 1'b0;
        case (cmd_stage)
            ST_BANG: begin
                if (c == CH_BANG) begin
                    cmd_stage = ST_BANG;
                end else if (letter_match(c, CH_R)) begin
                    r.echo    = 1'b1;
                    cmd_stage = ST_R;
                end else if (letter_match(c, CH_O)) begin
                    r.echo    = 1'b1;
                    cmd_stage = ST_O;
                end else begin
                    cmd_stage = ST_IDLE;
                end
            end
            ST_R: begin
                cmd_stage = letter_step(c, CH_R, CH_S, ST_R, ST_S, e);
                r.echo    = e;
            end
            ST_S: begin
                cmd_stage = letter_step(c, CH_S, CH_T, ST_S, ST_T, e);
                r.echo    = e;
            end
            ST_T: begin
                cmd_stage = letter_step(c, CH_T, CH_HASH, ST_T, ST_RSTDONE, e);
                r.echo    = e;
            end
            ST_O: begin
                cmd_stage = letter_step(c, CH_O, CH_K, ST_O, ST_K, e);
                r.echo    = e;
            end
            ST_K: begin
                cmd_stage = letter_step(c, CH_K, CH_HASH, ST_K, ST_OKDONE, e);
                r.echo    = e;
            end
            ST_RSTDONE: begin
                r.newline   = 1'b1;
                latched_cmd = FLAG_RST;
                cmd_stage   = ST_IDLE;
            end
            ST_OKDONE: begin
                r.newline   = 1'b1;
                latched_cmd = FLAG_OK;
                cmd_stage   = ST_IDLE;
            end
            default: begin
                if (c == CH_BANG) begin
                    r.echo    = 1'b1;
                    cmd_stage = ST_BANG;
                end else begin
                    cmd_stage = ST_IDLE;
                end
            end
        endcase
        r.flag = latched_cmd;
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_echo_result seen;
        t_echo_result want;
        if (!i_rst_n) begin
            cmd_stage   = ST_IDLE;
            latched_cmd = FLAG_NONE;
            echo_queue.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                seen.echo    = i_echo_valid;
                seen.ch      = i_echo_char;
                seen.newline = i_newline_valid;
                seen.flag    = i_command_flag;
                if (echo_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"csd_checker: unexpected result",
                                  " echo=%0b char=%02h nl=%0b flag=%0d"},
                                 seen.echo, seen.ch, seen.newline, seen.flag);
                end else begin
                    want = echo_queue.pop_front();
                    if (seen.echo !== want.echo || seen.ch !== want.ch ||
                        seen.newline !== want.newline || seen.flag !== want.flag) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"csd_checker: mismatch expected echo=%0b char=%02h nl=%0b",
                                      " flag=%0d, got echo=%0b char=%02h nl=%0b flag=%0d"},
                                     want.echo, want.ch, want.newline, want.flag,
                                     seen.echo, seen.ch, seen.newline, seen.flag);
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                echo_queue.push_back(predict_echo(i_rx_char));
        end
        waiting = echo_queue.size();
    end

endmodule

FILE: verif/tb.sv
// Testbench top for the command sequence detector: stimulus, idling, watchdog and verdict.
module tb;
    import csd_pkg::*;

    localparam int NUM_ITEMS      = 1000;
    localparam int WATCHDOG_LIMIT = 1000;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [CHAR_W-1:0] i_rx_char;
    logic              o_out_valid;
    logic              i_out_stall;
    logic              o_echo_valid;
    logic [CHAR_W-1:0] o_echo_char;
    logic              o_newline_valid;
    logic [FLAG_W-1:0] o_command_flag;

    int mismatch_count;
    int results_pending;
    int bytes_sent   = 0;
    int gap_pct      = 20;
    int stall_pct    = 20;
    int stall_left   = 0;
    int idle_cycles  = 0;
    bit quiet        = 1'b0;
    bit drained_once = 1'b0;

    logic [CHAR_W-1:0] directed[] = '{8'h00, 8'hFF, "!", "R", "r", "s", "S", "T", "#", "!",
                                      "!", "!", "o", "O", "k", "K", "#", 8'hA5,
                                      "!", "r", "s", "X", "!", "Q"};

    command_sequence_detector uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_rx_char       (i_rx_char),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_echo_valid    (o_echo_valid),
        .o_echo_char     (o_echo_char),
        .o_newline_valid (o_newline_valid),
        .o_command_flag  (o_command_flag)
    );

    csd_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_rx_char       (i_rx_char),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_echo_valid    (o_echo_valid),
        .i_echo_char     (o_echo_char),
        .i_newline_valid (o_newline_valid),
        .i_command_flag  (o_command_flag),
        .o_errors        (mismatch_count),
        .o_pending       (results_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (quiet) begin
                stall_left = 0;
                i_out_stall <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if ($urandom_range(0, 99) < stall_pct) begin
                stall_left = $urandom_range(0, 13);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic send_byte(input logic [CHAR_W-1:0] b);
        if ($urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_char  <= b;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_command(input bit want_ok);
        logic [CHAR_W-1:0] word[$];
        logic [CHAR_W-1:0] b;
        int                bad_pos;
        if (want_ok)
            word = '{CH_BANG, CH_O, CH_K, CH_HASH};
        else
            word = '{CH_BANG, CH_R, CH_S, CH_T, CH_HASH};
        bad_pos = ($urandom_range(0, 99) < 12) ? int'($urandom_range(0, word.size() - 1)) : -1;
        foreach (word[k]) begin
            if (k == bad_pos)
                b = CHAR_W'($urandom_range(0, 255));
            else
                b = word[k] | ($urandom_range(0, 1) ? CASE_BIT : '0);
            send_byte(b);
            if (k != bad_pos && word[k] != CH_HASH && $urandom_range(0, 99) < 20)
                repeat ($urandom_range(1, 2))
                    send_byte(word[k] | ($urandom_range(0, 1) ? CASE_BIT : '0));
        end
        send_byte(CHAR_W'($urandom_range(0, 255)));
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_rx_char  = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[k])
            send_byte(directed[k]);

        while (bytes_sent < NUM_ITEMS) begin
            if (bytes_sent >= 850) begin
                quiet   = 1'b1;
                gap_pct = 0;
            end else if (bytes_sent >= 300 && bytes_sent < 500) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else begin
                gap_pct   = 20;
                stall_pct = 20;
            end
            if (!drained_once && bytes_sent >= 500) begin
                drained_once = 1'b1;
                i_in_valid <= 1'b0;
                @(negedge i_clk);
                while (results_pending != 0) @(negedge i_clk);
            end
            if ($urandom_range(0, 99) < 75)
                send_command($urandom_range(0, 1));
            else
                repeat ($urandom_range(1, 4)) send_byte(CHAR_W'($urandom_range(0, 255)));
        end

        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (results_pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        if (mismatch_count == 0 && results_pending == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/csd_pkg.sv
hw/rtl/command_sequence_detector.sv
verif/csd_checker.sv
verif/tb.sv
